@@ rtl/core/cles_pkg.sv @@
// shared constants and types for the closed-loop error spike neuron
package cles_pkg;
  localparam int unsigned WindowLenDef = 50;
  localparam int unsigned PolarityDef = 1;
  localparam logic [24:0] DecayQ24 = 25'd16499913;
  localparam logic [18:0] AmpQ16 = 19'd378372;
  localparam logic [23:0] TraceMax = 24'hFFFFFF;
  localparam logic [16:0] CrLead = 17'd200;
  localparam logic signed [17:0] OneQ16 = 18'sd65536;
  localparam logic signed [17:0] HalfQ16 = 18'sd32768;

  typedef enum logic [2:0] {
    REG_PROTOCOL = 3'd0,
    REG_SPLIT_ID = 3'd1,
    REG_AVG_RECIP = 3'd2,
    REG_GAIN = 3'd3,
    REG_STIM_ONSET = 3'd4,
    REG_STIM_LENGTH = 3'd5,
    REG_TRIAL_LENGTH = 3'd6,
    REG_ACQ_TRIALS = 3'd7
  } reg_index_t;

  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_EYEBLINK = 2'd1;
  localparam logic [1:0] PROTO_VOR = 2'd2;
  localparam logic [1:0] PROTO_RSVD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACE,
    ST_RING,
    ST_AVG,
    ST_ERR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] protocol;
    logic [15:0] split_id;
    logic [23:0] avg_recip;
    logic [23:0] gain;
    logic [15:0] stim_onset;
    logic [15:0] stim_length;
    logic [15:0] trial_length;
    logic [15:0] acquisition_trials;
  } cfg_t;
endpackage

@@ rtl/core/cles_cfg.sv @@
// configuration register file
module cles_cfg import cles_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output cfg_t        cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{protocol: 2'd0, split_id: 16'd1, avg_recip: 24'd335544,
               gain: 24'd65536, stim_onset: 16'd0, stim_length: 16'd0,
               trial_length: 16'd1000, acquisition_trials: 16'd0};
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PROTOCOL:     cfg.protocol <= cfg_data[1:0];
        REG_SPLIT_ID:     cfg.split_id <= cfg_data[15:0];
        REG_AVG_RECIP:    cfg.avg_recip <= cfg_data;
        REG_GAIN:         cfg.gain <= cfg_data;
        REG_STIM_ONSET:   cfg.stim_onset <= cfg_data[15:0];
        REG_STIM_LENGTH:  cfg.stim_length <= cfg_data[15:0];
        REG_TRIAL_LENGTH: cfg.trial_length <= cfg_data[15:0];
        REG_ACQ_TRIALS:   cfg.acquisition_trials <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/cles_ring.sv @@
// trace-difference ring memory with fill count
module cles_ring import cles_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WindowLenDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic               wr_en,
  input  logic signed [24:0] wr_data,
  output logic signed [24:0] old_data
);
  localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  logic signed [24:0] mem [WINDOW_LEN];
  logic [AW-1:0] ptr;
  logic [AW:0] fill;
  logic signed [24:0] rd_q;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[ptr];
    if (wr_en) mem[ptr] <= wr_data;
  end

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      fill <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (rd_en) rd_valid <= (fill >= (AW+1)'(WINDOW_LEN));
      if (wr_en) begin
        ptr <= (ptr == AW'(WINDOW_LEN - 1)) ? '0 : ptr + 1'b1;
        if (fill < (AW+1)'(WINDOW_LEN)) fill <= fill + 1'b1;
      end
    end
  end

  assign old_data = rd_valid ? rd_q : 25'sd0;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= AW'(WINDOW_LEN - 1)) else $error("ring pointer out of range");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(WINDOW_LEN)) else $error("fill count overrun");
  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en)) else $error("ring read and write in one cycle");
`endif
endmodule

@@ rtl/core/closed_loop_error_spike_neuron.sv @@
// closed-loop error spike neuron: spikes accumulate, each tick item yields one result
// channel in: in_valid/in_ready with kind, sender_id, receptor_port,
//   random_value, desired_value. kind 0 is a spike item, counted on receptor port 0,
//   no result. kind 1 is a tick item and produces exactly one result item.
// channel out: out_valid/out_ready with spike_out, average_out, error_out,
//   cr_detected, trial_number, held in an output register.
// ticks: a tick passes the states trace, ring, average, error and output before
//   its result is registered. one tick is in work at a time, and no item enters
//   until it is done; the next item may enter while the last result still waits
//   in the output register, but a new tick stalls until that register is free.
// the tick sequence is set by the ring memory read-modify-write (a read state,
//   then a write state) and the two multiplies average and gain.
// configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// reset: synchronous rst clears traces, counters, config to defaults, and
//   marks the ring empty via a fill count (no clearing pass).
// a stalled receiver holds the result; no result is dropped or repeated.
module closed_loop_error_spike_neuron import cles_pkg::*; #(
  parameter int unsigned WINDOW_LEN = WindowLenDef,
  parameter int unsigned POLARITY = PolarityDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [15:0]        sender_id,
  input  logic [7:0]         receptor_port,
  input  logic [15:0]        random_value,
  input  logic signed [23:0] desired_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               spike_out,
  output logic signed [23:0] average_out,
  output logic signed [17:0] error_out,
  output logic               cr_detected,
  output logic [15:0]        trial_number,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  cfg_t cfg;
  state_t state, state_next;

  logic [7:0] pend_p, pend_n;
  logic [23:0] trace_p, trace_n;
  logic signed [31:0] wsum;
  logic [15:0] tick_pos, trial_cnt;
  logic cr_flag;
  logic [15:0] rnd_q;
  logic signed [23:0] des_q;
  logic signed [24:0] diff;
  logic signed [24:0] old_val;
  logic signed [23:0] avg;
  logic signed [17:0] err;
  logic [15:0] pos;
  logic ring_rd, ring_wr;

  cles_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);
  cles_ring #(.WINDOW_LEN(WINDOW_LEN)) u_ring (
    .clk, .rst, .rd_en(ring_rd), .wr_en(ring_wr), .wr_data(diff),
    .old_data(old_val));

  wire in_fire = in_valid && in_ready;
  wire tick_go = in_fire && kind;

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    ring_rd = 1'b0;
    ring_wr = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !(kind && out_valid);
        if (tick_go) state_next = ST_TRACE;
      end
      ST_TRACE: begin
        ring_rd = 1'b1;
        state_next = ST_RING;
      end
      ST_RING: begin
        ring_wr = 1'b1;
        state_next = ST_AVG;
      end
      ST_AVG: state_next = ST_ERR;
      ST_ERR: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // trace update: decay then kernel amplitudes
  function automatic logic [23:0] trace_upd(input logic [23:0] tr, input logic [7:0] pd);
    logic [48:0] m;
    logic [26:0] s;
    begin
      m = {25'd0, tr} * {24'd0, DecayQ24};
      s = {3'd0, m[47:24]} + 27'({8'd0, pd} * {8'd0, AmpQ16});
      trace_upd = (s > {3'd0, TraceMax}) ? TraceMax : s[23:0];
    end
  endfunction

  // average product, round toward zero
  logic signed [32:0] sum_new;
  logic [55:0] avg_prod;
  logic [31:0] sum_mag;
  logic [31:0] avg_mag;
  logic sum_neg;
  // gain product
  logic [47:0] g_prod;
  logic [31:0] g_mag;
  logic [23:0] avg_abs;
  logic signed [33:0] verr;
  logic [16:0] tl;
  logic in_stim, cr_win, acq;
  logic signed [17:0] err_next;
  logic cr_next;

  assign sum_new = 33'(wsum) - 33'(old_val) + 33'(diff);
  assign sum_neg = wsum[31];
  assign sum_mag = sum_neg ? 32'(-wsum) : 32'(wsum);
  assign avg_prod = {24'd0, sum_mag} * {32'd0, cfg.avg_recip};
  assign avg_mag = avg_prod[55:24];
  assign avg_abs = avg[23] ? 24'(-avg) : avg;
  assign g_prod = {24'd0, avg_abs} * {24'd0, cfg.gain};
  assign g_mag = g_prod[47:16];
  assign tl = (cfg.trial_length == 16'd0) ? 17'd1 : {1'b0, cfg.trial_length};
  assign in_stim = ({1'b0, pos} >= {1'b0, cfg.stim_onset}) &&
                   ({1'b0, pos} < {1'b0, cfg.stim_onset} + {1'b0, cfg.stim_length});
  assign cr_win = (pos < cfg.stim_onset) &&
                  ({1'b0, pos} + CrLead > {1'b0, cfg.stim_onset});
  assign acq = (trial_cnt <= cfg.acquisition_trials) && (POLARITY != 0);
  assign verr = 34'(des_q) - (avg[23] ? -34'({2'd0, g_mag}) : 34'({2'd0, g_mag}));

  always_comb begin
    err_next = 18'sd0;
    cr_next = cr_flag;
    if (cfg.protocol == PROTO_EYEBLINK) begin
      if (acq && in_stim) err_next = cr_flag ? HalfQ16 : OneQ16;
      if (cr_win && (32'(avg) > $signed({8'd0, cfg.gain})) && !cr_flag) cr_next = 1'b1;
    end else if (cfg.protocol == PROTO_VOR) begin
      if (verr > 34'(OneQ16)) err_next = OneQ16;
      else if (verr < -34'(OneQ16)) err_next = -OneQ16;
      else err_next = verr[17:0];
    end
  end

  logic [22:0] rnd100;
  logic fire;
  assign rnd100 = 23'(rnd_q) * 23'd100;
  assign fire = (POLARITY != 0) ? (err > 0 && 23'(err) > rnd100)
                                : (err < 0 && 23'(-err) > rnd100);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_p <= '0; pend_n <= '0; trace_p <= '0; trace_n <= '0;
      wsum <= '0; tick_pos <= '0; trial_cnt <= '0; cr_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_fire && !kind && receptor_port == 8'd0) begin
        if (sender_id < cfg.split_id) begin
          if (pend_p != 8'hFF) pend_p <= pend_p + 1'b1;
        end else if (pend_n != 8'hFF) pend_n <= pend_n + 1'b1;
      end
      if (tick_go) begin
        rnd_q <= random_value;
        des_q <= desired_value;
      end
      case (state)
        ST_TRACE: begin
          trace_p <= trace_upd(trace_p, pend_p);
          trace_n <= trace_upd(trace_n, pend_n);
          pend_p <= '0; pend_n <= '0;
        end
        ST_RING: begin
          wsum <= sum_new[31:0];
          // trial position, after wrap
          pos <= ({1'b0, tick_pos} >= tl) ? 16'd0 : tick_pos;
        end
        ST_AVG: begin
          if (avg_mag > 32'd8388607)
            avg <= sum_neg ? -24'sd8388608 : 24'sd8388607;
          else avg <= sum_neg ? -$signed(avg_mag[23:0]) : $signed(avg_mag[23:0]);
          if (pos == 16'd0) begin
            if (trial_cnt != 16'hFFFF) trial_cnt <= trial_cnt + 1'b1;
            cr_flag <= 1'b0;
          end
        end
        ST_ERR: begin
          err <= err_next;
          cr_flag <= cr_next;
          tick_pos <= ({1'b0, pos} + 17'd1 >= tl) ? 16'd0 : pos + 1'b1;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          spike_out <= fire;
          average_out <= avg;
          error_out <= err;
          cr_detected <= cr_flag;
          trial_number <= trial_cnt;
        end
        default: ;
      endcase
    end
  end

  assign diff = $signed({1'b0, trace_p}) - $signed({1'b0, trace_n});

`ifndef SYNTHESIS
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("item taken mid tick");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !out_valid) else $error("result overwritten");
  a_err_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_out <= OneQ16 && error_out >= -OneQ16))
    else $error("error outside clamp");
`endif
endmodule
